/* hw/rtl/ogru_pkg.sv */
// ogru_pkg: grid geometry, fixed-point reset values, command and state codes,
// walker interface structs and grid address helpers. no dependencies
`default_nettype none
package ogru_pkg;

  localparam int GRID_W        = 256;
  localparam int GRID_H        = 256;
  localparam int FRACTION_BITS = 8;
  localparam int CELLS         = GRID_W * GRID_H;
  localparam int ADDR_W        = $clog2(CELLS);
  localparam int COORD_W       = 16;

  localparam int ONE      = 1 << FRACTION_BITS;
  localparam int OCC_RAW  = (85 * ONE + 50) / 100;
  localparam int FREE_RAW = -((40 * ONE + 50) / 100);
  localparam int FLR_RAW  = -2 * ONE;
  localparam int CEIL_RAW = (7 * ONE) / 2;
  localparam int OCC_RST  = (OCC_RAW > 1023) ? 1023 : OCC_RAW;
  localparam int FREE_RST = (FREE_RAW < -1024) ? -1024 : FREE_RAW;
  localparam int FLR_RST  = (FLR_RAW < -2048) ? -2048 : FLR_RAW;
  localparam int CEIL_RST = (CEIL_RAW > 2047) ? 2047 : CEIL_RAW;

  typedef enum logic [2:0] {
    CMD_RAY   = 3'd0,
    CMD_REFL  = 3'd1,
    CMD_MERGE = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_OCC  = 2'd0,
    CFG_FREE = 2'd1,
    CFG_FLR  = 2'd2,
    CFG_CEIL = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RAY_CHECK,
    ST_REFL_CHECK,
    ST_CELL_WR,
    ST_MERGE,
    ST_MERGE_LAST,
    ST_CLEAR_MAP,
    ST_READ_RD,
    ST_READ_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic                      at_goal;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } walk_stat_t;

  function automatic logic in_grid(logic signed [COORD_W:0] x, logic signed [COORD_W:0] y);
    in_grid = (x >= 0) && (x < (COORD_W+1)'(GRID_W)) &&
              (y >= 0) && (y < (COORD_W+1)'(GRID_H));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic signed [COORD_W:0] x,
                                                 logic signed [COORD_W:0] y);
    cell_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(GRID_W)) + ADDR_W'(x);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ogru_ram.sv */
// ogru_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none
module ogru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hw/rtl/ogru_walker.sv */
// ogru_walker: bresenham line stepper, one cell per step
// depends on ogru_pkg
`default_nettype none
module ogru_walker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ogru_pkg::walk_ctrl_t               ctrl_i,
  input  wire logic signed [ogru_pkg::COORD_W-1:0] start_x_i,
  input  wire logic signed [ogru_pkg::COORD_W-1:0] start_y_i,
  input  wire logic signed [ogru_pkg::COORD_W-1:0] goal_x_i,
  input  wire logic signed [ogru_pkg::COORD_W-1:0] goal_y_i,
  output ogru_pkg::walk_stat_t                    stat_o
);

  localparam int CW = ogru_pkg::COORD_W;

  logic signed [CW-1:0] x_q, x_d, y_q, y_d, gx_q, gy_q;
  logic signed [CW+1:0] err_q, err_d;
  logic [CW:0]          dx_q, dy_q;
  logic                 sx_q, sy_q;

  logic signed [CW:0]   diff_x, diff_y;
  logic [CW:0]          adx, ady;
  logic signed [CW+2:0] e2;
  logic                 mv_x, mv_y;

  always_comb begin
    diff_x = $signed({goal_x_i[CW-1], goal_x_i}) - $signed({start_x_i[CW-1], start_x_i});
    diff_y = $signed({goal_y_i[CW-1], goal_y_i}) - $signed({start_y_i[CW-1], start_y_i});
    adx    = diff_x[CW] ? (CW+1)'(-diff_x) : diff_x;
    ady    = diff_y[CW] ? (CW+1)'(-diff_y) : diff_y;
    e2     = {err_q, 1'b0};
    mv_x   = e2 > -$signed({2'b00, dy_q});
    mv_y   = e2 < $signed({2'b00, dx_q});
    x_d    = x_q;
    y_d    = y_q;
    err_d  = err_q;
    if (ctrl_i.load) begin
      x_d   = start_x_i;
      y_d   = start_y_i;
      err_d = $signed({1'b0, adx}) - $signed({1'b0, ady});
    end else if (ctrl_i.step) begin
      err_d = err_q - (mv_x ? $signed({1'b0, dy_q}) : '0)
                    + (mv_y ? $signed({1'b0, dx_q}) : '0);
      if (mv_x) begin
        x_d = sx_q ? x_q + CW'(1) : x_q - CW'(1);
      end
      if (mv_y) begin
        y_d = sy_q ? y_q + CW'(1) : y_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      err_q <= '0;
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      gx_q <= goal_x_i;
      gy_q <= goal_y_i;
      dx_q <= adx;
      dy_q <= ady;
      sx_q <= start_x_i < goal_x_i;
      sy_q <= start_y_i < goal_y_i;
    end
  end

  assign stat_o.at_goal = (x_q == gx_q) && (y_q == gy_q);
  assign stat_o.x       = x_q;
  assign stat_o.y       = y_q;

endmodule
`default_nettype wire

/* hw/rtl/ogru_cell_alu.sv */
// ogru_cell_alu: shared add and clamp unit for cell updates and map merging
// no dependencies
`default_nettype none
module ogru_cell_alu (
  input  wire logic signed [15:0] a_i,
  input  wire logic signed [15:0] b_i,
  input  wire logic signed [16:0] lo_i,
  input  wire logic signed [16:0] hi_i,
  output logic signed      [15:0] res_o
);

  logic signed [16:0] sum;
  logic signed [16:0] v;

  always_comb begin
    sum = $signed({a_i[15], a_i}) + $signed({b_i[15], b_i});
    v   = sum;
    if (v < lo_i) begin
      v = lo_i;
    end
    // ceiling wins when floor sits above it
    if (v > hi_i) begin
      v = hi_i;
    end
    res_o = v[15:0];
  end

endmodule
`default_nettype wire

/* hw/rtl/occupancy_grid_ray_update_top.sv */
// occupancy_grid_ray_update_top: command sequencer, config registers and map memories
// depends on ogru_pkg, ogru_ram, ogru_walker, ogru_cell_alu
//
//  port group   direction  handshake         contents
//  command      in         start_i / busy_o  cmd, start/end cell, hit
//  result       out        done_o strobe     cell_value, inside_grid
//  config       in         cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// a ray visits each cell on the line in ST_RAY_CHECK and each grid cell also in
// ST_CELL_WR (read, then write of the frame memory); a reflector does so for its nine
// cells. merge sweeps the memories one cell a cycle and ends in ST_MERGE_LAST; clear
// sweeps the global map. read and unused commands pass ST_READ_RD, ST_READ_OUT. after
// reset a clearing pass keeps busy_o high. results cannot be stalled.
`default_nettype none
module occupancy_grid_ray_update_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic signed [15:0] start_x_i,
  input  wire logic signed [15:0] start_y_i,
  input  wire logic signed [15:0] end_x_i,
  input  wire logic signed [15:0] end_y_i,
  input  wire logic               hit_i,
  output logic                    done_o,
  output logic signed [15:0]      cell_value_o,
  output logic                    inside_grid_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [11:0]        cfg_wdata_i
);

  localparam int AW = ogru_pkg::ADDR_W;
  localparam int CW = ogru_pkg::COORD_W;

  ogru_pkg::state_e state_q, state_d;

  logic [9:0]         occ_q;
  logic signed [10:0] free_q;
  logic signed [11:0] flr_q;
  logic [10:0]        ceil_q;

  logic [2:0]           cmd_q;
  logic signed [CW-1:0] end_x_q, end_y_q;
  logic                 hit_q;
  logic                 inside_q;
  logic                 last_q, last_d;
  logic signed [10:0]   inc_q, inc_d;
  logic [AW-1:0]        tgt_q, tgt_d;
  logic [AW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        pipe_q, pipe_d;
  logic                 pipe_v_q, pipe_v_d;
  logic [3:0]           refl_q, refl_d;
  logic                 done_d;
  logic signed [15:0]   value_d;

  logic                 accept;
  logic signed [CW:0]   end_xe, end_ye, tx, ty, in_xe, in_ye;
  logic [1:0]           ox, oy;

  ogru_pkg::walk_ctrl_t wctrl;
  ogru_pkg::walk_stat_t wstat;

  logic [AW-1:0]        raddr;
  logic                 f_we, g_we;
  logic [AW-1:0]        f_waddr, g_waddr;
  logic [11:0]          f_wdata, f_rdata;
  logic [15:0]          g_wdata, g_rdata;

  logic signed [15:0]   alu_a, alu_b, alu_res;
  logic signed [16:0]   alu_lo, alu_hi;

  assign accept = start_i && !busy_o;
  assign busy_o = state_q != ogru_pkg::ST_IDLE;
  assign end_xe = {end_x_q[CW-1], end_x_q};
  assign end_ye = {end_y_q[CW-1], end_y_q};
  assign in_xe  = {end_x_i[CW-1], end_x_i};
  assign in_ye  = {end_y_i[CW-1], end_y_i};

  // reflector offsets: column outer, row inner, code 0..2 means -1..+1
  always_comb begin
    case (refl_q)
      4'd0:    begin ox = 2'd0; oy = 2'd0; end
      4'd1:    begin ox = 2'd0; oy = 2'd1; end
      4'd2:    begin ox = 2'd0; oy = 2'd2; end
      4'd3:    begin ox = 2'd1; oy = 2'd0; end
      4'd4:    begin ox = 2'd1; oy = 2'd1; end
      4'd5:    begin ox = 2'd1; oy = 2'd2; end
      4'd6:    begin ox = 2'd2; oy = 2'd0; end
      4'd7:    begin ox = 2'd2; oy = 2'd1; end
      default: begin ox = 2'd2; oy = 2'd2; end
    endcase
  end

  ogru_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (wctrl),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .goal_x_i  (end_x_i),
    .goal_y_i  (end_y_i),
    .stat_o    (wstat)
  );

  ogru_cell_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .lo_i  (alu_lo),
    .hi_i  (alu_hi),
    .res_o (alu_res)
  );

  ogru_ram #(.WIDTH(12), .DEPTH(ogru_pkg::CELLS)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (raddr),
    .rdata_o (f_rdata)
  );

  ogru_ram #(.WIDTH(16), .DEPTH(ogru_pkg::CELLS)) u_global_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (raddr),
    .rdata_o (g_rdata)
  );

  always_comb begin
    if (state_q == ogru_pkg::ST_CELL_WR) begin
      alu_a  = 16'(signed'(f_rdata));
      alu_b  = 16'(inc_q);
      alu_lo = 17'(flr_q);
      alu_hi = $signed({6'd0, ceil_q});
    end else begin
      alu_a  = g_rdata;
      alu_b  = 16'(signed'(f_rdata));
      alu_lo = -17'sd32768;
      alu_hi = 17'sd32767;
    end
  end

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    inc_d    = inc_q;
    tgt_d    = tgt_q;
    cnt_d    = cnt_q;
    pipe_d   = pipe_q;
    pipe_v_d = pipe_v_q;
    refl_d   = refl_q;
    done_d   = 1'b0;
    value_d  = '0;
    wctrl    = '0;
    raddr    = cnt_q;
    f_we     = 1'b0;
    g_we     = 1'b0;
    f_waddr  = tgt_q;
    g_waddr  = cnt_q;
    f_wdata  = '0;
    g_wdata  = '0;
    tx       = {wstat.x[CW-1], wstat.x};
    ty       = {wstat.y[CW-1], wstat.y};

    case (state_q)
      ogru_pkg::ST_INIT: begin
        f_we    = 1'b1;
        g_we    = 1'b1;
        f_waddr = cnt_q;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == AW'(ogru_pkg::CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ogru_pkg::ST_IDLE;
        end
      end
      ogru_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_d    = '0;
          refl_d   = '0;
          pipe_v_d = 1'b0;
          case (cmd_i)
            ogru_pkg::CMD_RAY: begin
              wctrl.load = 1'b1;
              state_d    = ogru_pkg::ST_RAY_CHECK;
            end
            ogru_pkg::CMD_REFL:  state_d = ogru_pkg::ST_REFL_CHECK;
            ogru_pkg::CMD_MERGE: state_d = ogru_pkg::ST_MERGE;
            ogru_pkg::CMD_CLEAR: state_d = ogru_pkg::ST_CLEAR_MAP;
            default:             state_d = ogru_pkg::ST_READ_RD;
          endcase
        end
      end
      ogru_pkg::ST_RAY_CHECK: begin
        last_d = wstat.at_goal;
        inc_d  = (wstat.at_goal && hit_q) ? $signed({1'b0, occ_q}) : free_q;
        tgt_d  = ogru_pkg::cell_addr(tx, ty);
        raddr  = ogru_pkg::cell_addr(tx, ty);
        if (ogru_pkg::in_grid(tx, ty)) begin
          state_d = ogru_pkg::ST_CELL_WR;
        end else if (wstat.at_goal) begin
          done_d  = 1'b1;
          state_d = ogru_pkg::ST_IDLE;
        end else begin
          wctrl.step = 1'b1;
        end
      end
      ogru_pkg::ST_REFL_CHECK: begin
        tx     = end_xe + $signed({{(CW-1){1'b0}}, ox}) - (CW+1)'(1);
        ty     = end_ye + $signed({{(CW-1){1'b0}}, oy}) - (CW+1)'(1);
        last_d = refl_q == 4'd8;
        inc_d  = $signed({1'b0, occ_q});
        tgt_d  = ogru_pkg::cell_addr(tx, ty);
        raddr  = ogru_pkg::cell_addr(tx, ty);
        if (ogru_pkg::in_grid(tx, ty)) begin
          state_d = ogru_pkg::ST_CELL_WR;
        end else if (refl_q == 4'd8) begin
          done_d  = 1'b1;
          state_d = ogru_pkg::ST_IDLE;
        end else begin
          refl_d = refl_q + 1'b1;
        end
      end
      ogru_pkg::ST_CELL_WR: begin
        f_we    = 1'b1;
        f_wdata = alu_res[11:0];
        if (last_q) begin
          done_d  = 1'b1;
          state_d = ogru_pkg::ST_IDLE;
        end else if (cmd_q == ogru_pkg::CMD_RAY) begin
          wctrl.step = 1'b1;
          state_d    = ogru_pkg::ST_RAY_CHECK;
        end else begin
          refl_d  = refl_q + 1'b1;
          state_d = ogru_pkg::ST_REFL_CHECK;
        end
      end
      ogru_pkg::ST_MERGE: begin
        // read cell n while cell n-1 is written back
        f_we     = pipe_v_q;
        g_we     = pipe_v_q;
        f_waddr  = pipe_q;
        g_waddr  = pipe_q;
        g_wdata  = alu_res;
        pipe_d   = cnt_q;
        pipe_v_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == AW'(ogru_pkg::CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ogru_pkg::ST_MERGE_LAST;
        end
      end
      ogru_pkg::ST_MERGE_LAST: begin
        f_we    = 1'b1;
        g_we    = 1'b1;
        f_waddr = pipe_q;
        g_waddr = pipe_q;
        g_wdata = alu_res;
        done_d  = 1'b1;
        state_d = ogru_pkg::ST_IDLE;
      end
      ogru_pkg::ST_CLEAR_MAP: begin
        g_we  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AW'(ogru_pkg::CELLS - 1)) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = ogru_pkg::ST_IDLE;
        end
      end
      ogru_pkg::ST_READ_RD: begin
        raddr   = ogru_pkg::cell_addr(end_xe, end_ye);
        state_d = ogru_pkg::ST_READ_OUT;
      end
      ogru_pkg::ST_READ_OUT: begin
        if (cmd_q == ogru_pkg::CMD_READ && inside_q) begin
          value_d = g_rdata;
        end
        done_d  = 1'b1;
        state_d = ogru_pkg::ST_IDLE;
      end
      default: state_d = ogru_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ogru_pkg::ST_INIT;
      cnt_q    <= '0;
      pipe_v_q <= 1'b0;
      refl_q   <= '0;
      last_q   <= 1'b0;
      done_o   <= 1'b0;
      occ_q    <= 10'(ogru_pkg::OCC_RST);
      free_q   <= 11'(ogru_pkg::FREE_RST);
      flr_q    <= 12'(ogru_pkg::FLR_RST);
      ceil_q   <= 11'(ogru_pkg::CEIL_RST);
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pipe_v_q <= pipe_v_d;
      refl_q   <= refl_d;
      last_q   <= last_d;
      done_o   <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ogru_pkg::CFG_OCC:  occ_q  <= cfg_wdata_i[9:0];
          ogru_pkg::CFG_FREE: free_q <= cfg_wdata_i[10:0];
          ogru_pkg::CFG_FLR:  flr_q  <= cfg_wdata_i;
          ogru_pkg::CFG_CEIL: ceil_q <= cfg_wdata_i[10:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    inc_q  <= inc_d;
    tgt_q  <= tgt_d;
    pipe_q <= pipe_d;
    if (accept) begin
      cmd_q    <= cmd_i;
      end_x_q  <= end_x_i;
      end_y_q  <= end_y_i;
      hit_q    <= hit_i;
      inside_q <= ogru_pkg::in_grid(in_xe, in_ye);
    end
    if (done_d) begin
      cell_value_o  <= value_d;
      inside_grid_o <= inside_q;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("accepted command left the sequencer idle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while still working");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cmd_q != ogru_pkg::CMD_READ) |-> cell_value_o == 16'sd0)
    else $error("non-read command returned a cell value");

  a_global_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_we |-> (state_q == ogru_pkg::ST_MERGE || state_q == ogru_pkg::ST_MERGE_LAST ||
              state_q == ogru_pkg::ST_INIT || state_q == ogru_pkg::ST_CLEAR_MAP))
    else $error("global map written outside a sweep");

endmodule
`default_nettype wire

/* dv/testbench.sv */
// testbench for occupancy_grid_ray_update_top: drives commands and config writes and
// checks every result transfer against an in-bench grid predictor
// depends on ogru_pkg and the rtl under hw/rtl
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ogru_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int     REPORT_MAX  = 10;
  localparam int     DRAIN_GAP   = 8;

  typedef struct packed {
    logic signed [15:0] value;
    logic               on_map;
  } cell_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         cmd_i = CMD_READ;
  logic signed [15:0] start_x_i = '0;
  logic signed [15:0] start_y_i = '0;
  logic signed [15:0] end_x_i = '0;
  logic signed [15:0] end_y_i = '0;
  logic               hit_i = 1'b0;
  logic               done_o;
  logic signed [15:0] cell_value_o;
  logic               inside_grid_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = CFG_OCC;
  logic [11:0]        cfg_wdata_i = '0;

  occupancy_grid_ray_update_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // grid predictor state
  int frame_cells [CELLS];
  int global_cells[CELLS];
  int occ_inc, free_inc, floor_lvl, ceil_lvl;

  cell_result_t expected_results[$];
  int           mismatches = 0;
  longint       cycles = 0;
  bit           steady = 1'b0;

  function automatic bit on_grid(int x, int y);
    return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
  endfunction

  function automatic void bump_cell(int x, int y, int inc);
    int v;
    if (!on_grid(x, y)) return;
    v = frame_cells[y * GRID_W + x] + inc;
    if (v < floor_lvl) v = floor_lvl;
    if (v > ceil_lvl) v = ceil_lvl;
    frame_cells[y * GRID_W + x] = v;
  endfunction

  function automatic void trace_ray(int x0, int y0, int gx, int gy, bit hit);
    int dx, dy, sx, sy, wx, wy, err, e2;
    dx = (gx > x0) ? gx - x0 : x0 - gx;
    dy = (gy > y0) ? gy - y0 : y0 - gy;
    sx = (x0 < gx) ? 1 : -1;
    sy = (y0 < gy) ? 1 : -1;
    wx = x0;
    wy = y0;
    err = dx - dy;
    while (wx != gx || wy != gy) begin
      bump_cell(wx, wy, free_inc);
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        wx += sx;
      end
      if (e2 < dx) begin
        err += dx;
        wy += sy;
      end
    end
    bump_cell(gx, gy, hit ? occ_inc : free_inc);
  endfunction

  function automatic cell_result_t apply_command(logic [2:0] cmd, int x0, int y0,
                                                 int gx, int gy, bit hit);
    cell_result_t r;
    int s;
    r.on_map = on_grid(gx, gy);
    r.value  = '0;
    case (cmd)
      CMD_RAY: trace_ray(x0, y0, gx, gy, hit);
      CMD_REFL: begin
        for (int ox = -1; ox <= 1; ox++)
          for (int oy = -1; oy <= 1; oy++) bump_cell(gx + ox, gy + oy, occ_inc);
      end
      CMD_MERGE: begin
        for (int i = 0; i < CELLS; i++) begin
          s = global_cells[i] + frame_cells[i];
          if (s > 32767) s = 32767;
          if (s < -32768) s = -32768;
          global_cells[i] = s;
          frame_cells[i] = 0;
        end
      end
      CMD_CLEAR: begin
        foreach (global_cells[i]) global_cells[i] = 0;
      end
      CMD_READ: begin
        if (r.on_map) r.value = 16'(global_cells[gy * GRID_W + gx]);
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checking: one transfer per done strobe
  always @(posedge clk_i) begin
    cell_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** occupancy_grid_ray_update_top: FAILED **");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result transfer: value %0d inside %0b",
                   cell_value_o, inside_grid_o);
      end else begin
        want = expected_results.pop_front();
        if (cell_value_o !== want.value || inside_grid_o !== want.on_map) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: expected value %0d inside %0b, got %0d %0b",
                     want.value, want.on_map, cell_value_o, inside_grid_o);
        end
      end
    end
  end

  task automatic send_command(logic [2:0] cmd, logic signed [15:0] x0,
                              logic signed [15:0] y0, logic signed [15:0] gx,
                              logic signed [15:0] gy, bit hit);
    start_i   <= 1'b1;
    cmd_i     <= cmd;
    start_x_i <= x0;
    start_y_i <= y0;
    end_x_i   <= gx;
    end_y_i   <= gy;
    hit_i     <= hit;
    do @(posedge clk_i); while (busy_o);
    expected_results = {expected_results, apply_command(cmd, x0, y0, gx, gy, hit)};
    if (!steady && $urandom_range(99) < 6) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [11:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_OCC:  occ_inc   = int'(data[9:0]);
      CFG_FREE: free_inc  = int'($signed(data[10:0]));
      CFG_FLR:  floor_lvl = int'($signed(data[11:0]));
      CFG_CEIL: ceil_lvl  = int'(data[10:0]);
      default: ;
    endcase
  endtask

  task automatic set_levels(int occ, int free, int flr, int ceil);
    wait_idle();
    write_reg(CFG_OCC, 12'(occ));
    write_reg(CFG_FREE, 12'(free));
    write_reg(CFG_FLR, 12'(flr));
    write_reg(CFG_CEIL, 12'(ceil));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] near_grid();
    return 16'($urandom_range(0, GRID_W + 15) - 8);
  endfunction

  // extremes of the fields, every command, edges and off-grid cells
  task automatic test_directed();
    send_command(CMD_READ, 0, 0, 0, 0, 0);
    send_command(CMD_RAY, 10, 10, 10, 10, 1);
    send_command(CMD_RAY, 10, 10, 10, 10, 0);
    send_command(CMD_RAY, 0, 0, 20, 7, 1);
    send_command(CMD_RAY, 20, 30, 3, 2, 0);
    send_command(CMD_RAY, -5, -3, 6, 4, 1);
    send_command(CMD_RAY, 250, 250, 260, 262, 1);
    send_command(CMD_RAY, 16'sh7fff, 16'sh7fff, 255, 255, 1);
    send_command(CMD_RAY, -16'sh8000, -16'sh8000, 0, 0, 0);
    send_command(CMD_REFL, 0, 0, 0, 0, 0);
    send_command(CMD_REFL, 0, 0, 255, 255, 1);
    send_command(CMD_REFL, 0, 0, 5, 5, 0);
    send_command(CMD_REFL, 0, 0, -1, 256, 0);
    send_command(CMD_MERGE, 0, 0, 5, 5, 0);
    send_command(CMD_READ, 0, 0, 5, 5, 0);
    send_command(CMD_READ, 0, 0, 255, 255, 0);
    send_command(CMD_READ, 0, 0, 256, 0, 0);
    send_command(CMD_READ, -1, -1, -16'sh8000, 16'sh7fff, 1);
    send_command(CMD_READ + 3'd1, 16'sh7fff, -1, 5, 5, 1);
    send_command(3'h7, -1, 16'sh7fff, 300, -2, 0);
    send_command(CMD_CLEAR, 0, 0, 5, 5, 0);
    send_command(CMD_READ, 0, 0, 5, 5, 0);
  endtask

  // register extremes, positive free step, floor above ceiling
  task automatic test_level_extremes();
    set_levels(1023, -1023, -2048, 2047);
    repeat (40) send_command(CMD_REFL, 0, 0, 40, 40, 1);
    repeat (40) send_command(CMD_RAY, 30, 45, 50, 35, 0);
    set_levels(0, 50, 0, 0);
    send_command(CMD_RAY, 30, 45, 50, 35, 1);
    send_command(CMD_REFL, 0, 0, 40, 40, 0);
    set_levels(7, 1023, 100, 20);
    send_command(CMD_RAY, 40, 38, 44, 42, 1);
    send_command(CMD_MERGE, 0, 0, 40, 40, 0);
    send_command(CMD_READ, 0, 0, 40, 40, 0);
    send_command(CMD_READ, 0, 0, 42, 40, 0);
  endtask

  // global saturation: merge a full ceiling many times
  task automatic test_saturation();
    set_levels(1023, -1024, -2048, 2047);
    for (int k = 0; k < 17; k++) begin
      send_command(CMD_REFL, 0, 0, 100, 100, 1);
      send_command(CMD_REFL, 0, 0, 100, 100, 1);
      send_command(CMD_RAY, 120, 110, 128, 110, 0);
      send_command(CMD_RAY, 120, 110, 128, 110, 0);
      send_command(CMD_MERGE, 0, 0, 100, 100, 0);
    end
    send_command(CMD_READ, 0, 0, 100, 100, 0);
    send_command(CMD_READ, 0, 0, 124, 110, 0);
    send_command(CMD_CLEAR, 0, 0, 0, 0, 0);
  endtask

  task automatic random_item();
    int pick;
    logic signed [15:0] x0, y0;
    pick = $urandom_range(999);
    x0 = near_grid();
    y0 = near_grid();
    if (pick < 3)
      send_command(CMD_MERGE, 16'($urandom), 16'($urandom), near_grid(), near_grid(),
                   1'($urandom));
    else if (pick < 4)
      send_command(CMD_CLEAR, 16'($urandom), 16'($urandom), near_grid(), near_grid(),
                   1'($urandom));
    else if (pick < 600) begin
      if ($urandom_range(15) == 0)
        send_command(CMD_RAY, x0, y0, x0, y0, 1'($urandom));
      else
        send_command(CMD_RAY, x0, y0, x0 + 16'($urandom_range(0, 80) - 40),
                     y0 + 16'($urandom_range(0, 80) - 40), 1'($urandom));
    end else if (pick < 750)
      send_command(CMD_REFL, 16'($urandom), 16'($urandom),
                   ($urandom_range(9) == 0) ? 16'($urandom) : x0,
                   ($urandom_range(9) == 0) ? 16'($urandom) : y0, 1'($urandom));
    else if (pick < 960) begin
      if ($urandom_range(3) == 0)
        send_command(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 1'($urandom));
      else
        send_command(CMD_READ, 16'($urandom), 16'($urandom), x0, y0, 1'($urandom));
    end else
      send_command(3'($urandom_range(CMD_READ + 1, 7)), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_levels(OCC_RST, FREE_RST, FLR_RST, CEIL_RST);
        1: set_levels($urandom_range(1023), -$urandom_range(1023),
                      -$urandom_range(2048), $urandom_range(2047));
        2: set_levels(1023, -1023, -2048, 2047);
        default: set_levels($urandom_range(300), -$urandom_range(300),
                            -$urandom_range(600), $urandom_range(900));
      endcase
      for (int n = 0; n < 280; n++) begin
        steady = (phase == 2);
        random_item();
      end
      steady = 1'b0;
      send_command(CMD_MERGE, 0, 0, 0, 0, 0);
      for (int n = 0; n < 10; n++)
        send_command(CMD_READ, 0, 0, near_grid(), near_grid(), 0);
    end
  endtask

  initial begin
    occ_inc   = OCC_RST;
    free_inc  = FREE_RST;
    floor_lvl = FLR_RST;
    ceil_lvl  = CEIL_RST;
    foreach (frame_cells[i]) begin
      frame_cells[i]  = 0;
      global_cells[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_level_extremes();
    test_saturation();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("** occupancy_grid_ray_update_top: PASSED **");
    else
      $display("** occupancy_grid_ray_update_top: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

/* occupancy_grid_ray_update_top.f */
hw/rtl/ogru_pkg.sv
hw/rtl/ogru_ram.sv
hw/rtl/ogru_walker.sv
hw/rtl/ogru_cell_alu.sv
hw/rtl/occupancy_grid_ray_update_top.sv
dv/testbench.sv
